[sv/dtt_pkg.sv]
// Shared types, constants and byte classification functions for the tag tokenizer.
package dtt_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;
  localparam int CFG_W             = 6;
  localparam logic [CFG_W-1:0] MIN_TAG_LEN_RST = 6'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       delim;
    logic       eon;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_EMIT
  } back_state_t;

  function automatic logic is_delim(input logic [7:0] b);
    logic d;
    unique case (b)
      CH_UNDERSCORE, CH_SPACE, CH_HYPHEN, CH_DOT,
      CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[sv/dtt_front.sv]
// Front stage: takes input words, classifies and lower-cases them into one register.
module dtt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_name_byte,
  input  logic           in_end_of_name,
  output logic           op_valid,
  output dtt_pkg::op_t   op,
  input  logic           op_stall
);
  import dtt_pkg::*;

  logic op_valid_r, op_valid_nxt;
  op_t  op_r, op_nxt;
  logic load;

  // The stage refills in the same cycle that its word moves on.
  assign in_stall = op_valid_r && op_stall;
  assign load     = !in_stall;

  always_comb begin
    op_valid_nxt = op_valid_r;
    op_nxt       = op_r;
    if (load) begin
      op_valid_nxt = in_valid;
      op_nxt.data  = fold_lower(in_name_byte);
      op_nxt.delim = is_delim(in_name_byte);
      op_nxt.eon   = in_end_of_name;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign op_valid = op_valid_r;
  assign op       = op_r;

endmodule

[sv/dtt_queue.sv]
// Small first-in first-out queue of classified words between front and back.
module dtt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_stall,
  input  dtt_pkg::op_t   push_op,
  output logic           pop_valid,
  input  logic           pop_stall,
  output dtt_pkg::op_t   pop_op
);
  import dtt_pkg::*;

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_op     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

endmodule

[sv/dtt_back.sv]
// Back end: token buffer, length tracking and tag emission through an output register.
module dtt_back #(
  parameter int MAX_TOKEN_LEN = dtt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dtt_pkg::CFG_W-1:0] min_tag_length,
  input  logic                      op_valid,
  output logic                      op_stall,
  input  dtt_pkg::op_t              op,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_tag_byte,
  output logic                      out_last_of_tag
);
  import dtt_pkg::*;

  localparam int AW    = $clog2(MAX_TOKEN_LEN);
  localparam int LW    = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CW    = (LW > CFG_W) ? LW : CFG_W;

  back_state_t state_r, state_nxt;

  logic [7:0]    mem_r [MAX_TOKEN_LEN];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [LW-1:0] len_r, len_nxt, len_app;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic accept, app, close, emit, load, last;

  assign op_stall = (state_r != BK_IDLE);
  assign accept   = op_valid && (state_r == BK_IDLE);
  assign load     = !out_valid_r || !out_stall;
  assign last     = (LW'(idx_r) == len_r - LW'(1));

  always_comb begin
    app     = !op.delim && (len_r < LW'(MAX_TOKEN_LEN));
    len_app = app ? LW'(len_r + LW'(1)) : len_r;
    close   = op.delim || op.eon;
    emit    = close && (len_app != '0) && (CW'(len_app) >= CW'(min_tag_length));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (accept && emit) begin
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (load && last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs. The read address always tracks idx_nxt, so rd_data_r
  // holds the byte at idx_r throughout emission.
  always_comb begin
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          wr_en = app;
          if (close && !emit) begin
            len_nxt = '0;
          end else begin
            len_nxt = len_app;
          end
        end
      end
      BK_PREP: begin
        idx_nxt = '0;
      end
      BK_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = last;
          if (last) begin
            len_nxt = '0;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        len_nxt = '0;
      end
    endcase
    rd_addr = idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[len_r[AW-1:0]] <= op.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_tag_byte    = out_byte_r;
  assign out_last_of_tag = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_TOKEN_LEN))
    else $error("token length exceeds buffer depth");

  a_idx_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (LW'(idx_r) < len_r))
    else $error("emission index outside the token");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT && load && last) |=> (state_r == BK_IDLE && len_r == '0))
    else $error("token not cleared after its last byte");

endmodule

[sv/delimiter_tag_tokenizer.sv]
// Top level of the delimiter tag tokenizer: configuration register and the three stages.
//
// Usage: a file name enters on the in_ channel one byte per word, with
// in_end_of_name set on its final byte. Delimiter bytes (underscore, space,
// hyphen, dot, parentheses and square brackets) split the name into tokens.
// Other bytes are folded to lower case and buffered. A non-empty token that
// closes with at least min_tag_length bytes leaves on the out_ channel one
// byte per word, out_last_of_tag marking its final byte. Bytes past the
// buffer depth are dropped. The byte that closes a tag goes through the front
// register and the queue to the back end; the first tag byte leaves through
// the output register. Bytes are taken one per cycle while in_stall is low;
// each tag then holds the buffer while it is read out of the single read
// port of the token buffer, and the queue between front and back absorbs up
// to four bytes that arrive meanwhile. A valid output word holds while out_stall
// is high, and the stall backs up through the queue to in_stall. Reset (rst_n low,
// synchronous) empties the queue, the buffer length and the output word and sets
// min_tag_length to 3; write cfg_wr_data with cfg_wr_en only while idle.
module delimiter_tag_tokenizer #(
  parameter int MAX_TOKEN_LEN = dtt_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [dtt_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_name_byte,
  input  logic                      in_end_of_name,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_tag_byte,
  output logic                      out_last_of_tag
);
  import dtt_pkg::*;

  logic [CFG_W-1:0] min_len_r, min_len_nxt;

  logic front_valid, front_stall;
  op_t  front_op;
  logic back_valid, back_stall;
  op_t  back_op;

  // Threshold register; the user must write it only while the block is idle, the block itself does not enforce this.
  assign min_len_nxt = cfg_wr_en ? cfg_wr_data : min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_TAG_LEN_RST;
    end else begin
      min_len_r <= min_len_nxt;
    end
  end

  // Front: classification and case folding of each incoming byte.
  dtt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_byte   (in_name_byte),
    .in_end_of_name (in_end_of_name),
    .op_valid       (front_valid),
    .op             (front_op),
    .op_stall       (front_stall)
  );

  // Queue lets the front keep taking bytes while a tag is read out.
  dtt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_stall  (back_stall),
    .pop_op     (back_op)
  );

  // Back: token buffer and tag emission.
  dtt_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .min_tag_length  (min_len_r),
    .op_valid        (back_valid),
    .op_stall        (back_stall),
    .op              (back_op),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tag_byte    (out_tag_byte),
    .out_last_of_tag (out_last_of_tag)
  );

endmodule

[sim/tb.sv]
// Self-checking testbench for the delimiter tag tokenizer: prediction, stimulus and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtt_pkg::*;

  localparam int TOKEN_DEPTH = MAX_TOKEN_LEN_DEF;
  // Settling wait for a closing byte still inside the block before its tag, if
  // any, shows up: it goes through the front register and the queue to the back
  // end, then on to the output word, with margin for the queue between the stages.
  localparam int SETTLE_CYCLES = 24;

  // One word on the tag channel as the predictor expects it.
  typedef struct packed {
    logic [7:0] tag_byte;
    logic       is_last;
  } tag_word_t;

  // The tag tracker mirrors the token buffer of the block. Every name byte
  // taken by the block is fed to it; whenever a token closes long enough, the
  // words of the tag it produces are queued in order, and every word that
  // leaves the block is compared with the oldest one waiting.
  class tag_tracker;
    logic [7:0]  token_bytes [TOKEN_DEPTH];
    int unsigned token_len;
    logic [5:0]  min_len;
    tag_word_t   expected_tags [$];
    int          errors;

    function new();
      token_len = 0;
      min_len   = MIN_TAG_LEN_RST;
      errors    = 0;
    endfunction

    function void take_name_byte(logic [7:0] b, logic eon);
      logic       delim;
      logic [7:0] folded;
      tag_word_t  w;
      delim = b inside {CH_UNDERSCORE, CH_SPACE, CH_HYPHEN, CH_DOT,
                        CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET};
      folded = b;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
        folded = b + CASE_OFFSET;
      end
      // A full buffer silently drops further bytes, truncating the token.
      if (!delim && token_len < TOKEN_DEPTH) begin
        token_bytes[token_len] = folded;
        token_len++;
      end
      if (delim || eon) begin
        // An empty token never becomes a tag, whatever the threshold says.
        if (token_len > 0 && token_len >= min_len) begin
          for (int i = 0; i < token_len; i++) begin
            w.tag_byte = token_bytes[i];
            w.is_last  = (i + 1 == token_len);
            expected_tags = {expected_tags, w};
          end
        end
        token_len = 0;
      end
    endfunction

    function void check_tag_byte(logic [7:0] b, logic is_last);
      tag_word_t w;
      if (expected_tags.size() == 0) begin
        $error("unexpected tag word: tag_byte=%02h last_of_tag=%0b", b, is_last);
        errors++;
        return;
      end
      w = expected_tags.pop_front();
      if (b !== w.tag_byte) begin
        $error("tag_byte: expected %02h, got %02h", w.tag_byte, b);
        errors++;
      end
      if (is_last !== w.is_last) begin
        $error("last_of_tag: expected %0b, got %0b", w.is_last, is_last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_tags.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_name_byte;
  logic             in_end_of_name;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_tag_byte;
  logic             out_last_of_tag;

  tag_tracker tracker = new();

  // State of the stimulus and the receiver process; choke_pending is shared between them.
  logic       tx_burst;
  logic       rx_burst;
  logic       choke_pending;
  int         words_sent;
  logic [7:0] name_bytes [$];

  delimiter_tag_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_name_byte    (in_name_byte),
    .in_end_of_name  (in_end_of_name),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tag_byte    (out_tag_byte),
    .out_last_of_tag (out_last_of_tag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake locks up somewhere.
  initial begin
    #10ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [7:0] random_delim();
    logic [7:0] d;
    case ($urandom_range(0, 7))
      0: d = CH_UNDERSCORE;
      1: d = CH_SPACE;
      2: d = CH_HYPHEN;
      3: d = CH_DOT;
      4: d = CH_LPAREN;
      5: d = CH_RPAREN;
      6: d = CH_LBRACKET;
      default: d = CH_RBRACKET;
    endcase
    return d;
  endfunction

  // Offers one name byte after a random gap and returns at the edge where the
  // block takes it. The task is always entered right after a rising edge, and
  // in_valid is only written once per time step: lowered at the start of a
  // gap, raised again a whole number of cycles later.
  task automatic send_word(input logic [7:0] b, input logic eon);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) begin
      tx_burst = !tx_burst;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_name_byte   <= b;
    in_end_of_name <= eon;
    // The values read right after the edge are the ones the block saw.
    do @(posedge clk); while (in_stall);
    tracker.take_name_byte(b, eon);
    words_sent++;
  endtask

  // Sends name_bytes in order; the end-of-name flag goes on the last byte only
  // if asked, which lets a sequence also stop in the middle of a token.
  task automatic send_name_bytes(input logic eon_last);
    for (int i = 0; i < name_bytes.size(); i++) begin
      send_word(name_bytes[i], eon_last && (i == name_bytes.size() - 1));
    end
  endtask

  // A well-formed name: one to four tokens of random content split by one or two
  // delimiters, ending either on a token byte or on a delimiter. Long tokens can
  // overrun the buffer; they are common when the threshold is high so that
  // the full-buffer truncation actually produces tags.
  task automatic send_random_name();
    int n_tok;
    int tok_len;
    int long_pct;
    int kind;
    logic [7:0] b;
    long_pct = (tracker.min_len >= 6'd20) ? 40 : 8;
    n_tok = $urandom_range(1, 4);
    name_bytes = {};
    for (int t = 0; t < n_tok; t++) begin
      if ($urandom_range(0, 99) < long_pct) begin
        tok_len = $urandom_range(28, 40);
      end else begin
        tok_len = $urandom_range(0, 7);
      end
      for (int k = 0; k < tok_len; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          b = 8'h41 + 8'($urandom_range(0, 25));
        end else if (kind < 6) begin
          b = 8'h61 + 8'($urandom_range(0, 25));
        end else if (kind < 8) begin
          b = 8'h30 + 8'($urandom_range(0, 9));
        end else begin
          // Any byte at all, delimiters and high bytes included.
          b = 8'($urandom_range(0, 255));
        end
        name_bytes = {name_bytes, b};
      end
      if (t < n_tok - 1 || $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 2)) name_bytes = {name_bytes, random_delim()};
      end
    end
    if (name_bytes.size() == 0) begin
      name_bytes = {name_bytes, 8'h6D};
    end
    send_name_bytes(1'b1);
  endtask

  // Receiver: after each word it takes, it draws how long to hold off. On
  // request it holds off for a long stretch so the block backs up to in_stall.
  initial begin
    int hold;
    hold = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.check_tag_byte(out_tag_byte, out_last_of_tag);
        hold = rx_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) begin
          rx_burst = !rx_burst;
        end
      end
      if (choke_pending) begin
        hold = 200;
        choke_pending = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [5:0] phase_min [7];
    int         phase_end;
    int         kind;

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_name_byte   = '0;
    in_end_of_name = 1'b0;
    out_stall      = 1'b0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    choke_pending  = 1'b0;
    words_sent     = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset threshold of three.
    // Both ends of the upper- and lower-case ranges, 40, 60 and 7B just outside
    // them, zero and all-ones, closed by an underscore: one nine-byte tag.
    name_bytes = {8'h41, 8'h5A, 8'h40, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h61, 8'h7A,
                  CH_UNDERSCORE};
    send_name_bytes(1'b0);
    // Six more delimiters back to back: only empty tokens, no tag.
    name_bytes = {CH_SPACE, CH_HYPHEN, CH_DOT, CH_LPAREN, CH_RPAREN, CH_LBRACKET};
    send_name_bytes(1'b0);
    // A token one byte short of the threshold is swallowed.
    name_bytes = {8'h62, 8'h63, CH_RBRACKET};
    send_name_bytes(1'b0);
    // End flag on a token byte: the byte joins the token, then it closes.
    name_bytes = {8'h58, 8'h79, 8'h5A};
    send_name_bytes(1'b1);
    // End flag on a delimiter: the delimiter alone closes the token.
    name_bytes = {8'h51, 8'h52, 8'h53, CH_DOT};
    send_name_bytes(1'b1);
    // A name that is a lone delimiter.
    name_bytes = {CH_UNDERSCORE};
    send_name_bytes(1'b1);

    // Random phases, each at its own threshold: single-byte tags, the full
    // buffer depth, zero (empty tokens must still vanish), all ones (no tag can
    // come out), two, one past the depth (likewise), then one ordinary value.
    phase_min = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd33, 6'($urandom_range(4, 12))};
    for (int p = 0; p < 7; p++) begin
      // The threshold may only change while the block is empty: wait for the
      // last tag, then long enough for a closing byte without a tag to clear.
      in_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= phase_min[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      tracker.min_len = phase_min[p];

      // Squeeze the output on the phases that make many tags.
      if (p == 0 || p == 4) begin
        choke_pending = 1'b1;
      end

      phase_end = words_sent + 20;
      while (words_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
          send_random_name();
        end else if (kind < 93) begin
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_word(random_delim(), 1'($urandom_range(0, 1)));
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    // Anything that still comes out now is caught as unexpected.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/dtt_pkg.sv
sv/dtt_front.sv
sv/dtt_queue.sv
sv/dtt_back.sv
sv/delimiter_tag_tokenizer.sv
sim/tb.sv
